// ===== rtl/tpvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-plane video RAM: shared package
// Sizes, request codes, the structs passed between the sequencer and the
// read-modify-write logic, and the pixel row builder.
// ----------------------------------------------------------------------------
package tpvr_pkg;

  // Plane size in bytes and screen line length in bytes; both powers of two.
  localparam int PLANE_BYTES    = 8192;
  localparam int BYTES_PER_LINE = 32;

  localparam int ADDR_W = $clog2(PLANE_BYTES);
  localparam int OFS_W  = 13;
  localparam int BYTE_W = 8;
  // One memory word holds the same byte of all three planes.
  localparam int WORD_W = 3 * BYTE_W;
  localparam int ROW_W  = 24;

  // Request types.
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_SELECT = 2'd2;

  // Plane selector codes.
  localparam logic [1:0] SEL_PLANE0 = 2'd0;
  localparam logic [1:0] SEL_PLANE1 = 2'd1;
  localparam logic [1:0] SEL_PLANE2 = 2'd2;
  localparam logic [1:0] SEL_CLEAR  = 2'd3;

  // Selector bit addresses for a selector write.
  localparam logic [OFS_W-1:0] SEL_BIT0_OFS = OFS_W'(0);
  localparam logic [OFS_W-1:0] SEL_BIT1_OFS = OFS_W'(1);

  // Request held by the sequencer while it executes.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [OFS_W-1:0]  offset;
    logic [BYTE_W-1:0] data;
    logic [1:0]        sel;
  } req_t;

  // Write-back to the plane memory.
  typedef struct packed {
    logic              we;
    logic [WORD_W-1:0] wdata;
  } wb_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              row_valid;
    logic [7:0]        pixel_x;
    logic [7:0]        pixel_y;
    logic [ROW_W-1:0]  pixel_row;
  } result_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic clearing;
    logic exec;
  } seq_status_t;

  // Wrap a byte offset onto the plane size.
  function automatic logic [ADDR_W-1:0] plane_addr(logic [OFS_W-1:0] ofs);
    return ADDR_W'(32'(ofs) & (PLANE_BYTES - 1));
  endfunction

  // Build eight 3-bit pixels, leftmost pixel from bit 7 of each plane.
  function automatic logic [ROW_W-1:0] build_row(logic [WORD_W-1:0] word);
    logic [ROW_W-1:0] row;
    row = '0;
    for (int i = 0; i < 8; i++) begin
      row[3*i +: 3] = {word[7-i], word[BYTE_W+7-i], word[2*BYTE_W+7-i]};
    end
    return row;
  endfunction

endpackage

// ===== rtl/three_plane_video_ram.sv =====
// ----------------------------------------------------------------------------
// Three-plane video RAM
// Three bitplanes behind a plane selector, with pixel row output on writes.
// ----------------------------------------------------------------------------
// Each request is taken in a transfer cycle that reads the word holding
// the addressed byte of all three planes from a single-port memory; the
// execute state then writes the merged word back on a video write and
// loads the result register once that register is free. A new request is
// taken only after the execute state ends, so one request is in flight at
// a time; a stalled result holds the block in its execute state. After reset
// the block runs a clearing pass over all 8192 memory words (one memory word
// per cycle) before it takes its first request.
module three_plane_video_ram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [12:0] in_byte_offset,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_byte,
  output logic        out_row_valid,
  output logic [7:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [23:0] out_pixel_row
);

  tpvr_pkg::req_t                  req;
  tpvr_pkg::wb_t                   wb;
  tpvr_pkg::result_t               res;
  tpvr_pkg::seq_status_t           status;
  logic                            ram_we;
  logic                            ram_re;
  logic [tpvr_pkg::ADDR_W-1:0]     ram_addr;
  logic [tpvr_pkg::WORD_W-1:0]     ram_wdata;
  logic [tpvr_pkg::WORD_W-1:0]     ram_rdata;
  logic                            out_free;
  logic                            res_load;
  logic                            out_valid_r, out_valid_nxt;
  tpvr_pkg::result_t               res_r;

  // The result register is free when empty or when its transfer completes.
  assign out_free = !out_valid_r || !out_stall;
  assign res_load = status.exec && out_free;

  // Sequencer.
  tpvr_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_req_type    (in_req_type),
    .in_byte_offset (in_byte_offset),
    .in_write_byte  (in_write_byte),
    .in_stall       (in_stall),
    .out_free       (out_free),
    .wb             (wb),
    .req            (req),
    .status         (status),
    .ram_we         (ram_we),
    .ram_re         (ram_re),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata)
  );

  // Plane memory, one word per byte offset.
  tpvr_ram #(
    .WIDTH (tpvr_pkg::WORD_W),
    .DEPTH (tpvr_pkg::PLANE_BYTES)
  ) u_planes (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Merge and result formation.
  tpvr_rmw u_rmw (
    .req   (req),
    .rdata (ram_rdata),
    .wb    (wb),
    .res   (res)
  );

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = res_r.read_byte;
  assign out_row_valid = res_r.row_valid;
  assign out_pixel_x   = res_r.pixel_x;
  assign out_pixel_y   = res_r.pixel_y;
  assign out_pixel_row = res_r.pixel_row;

  // No result appears while the planes are being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> !out_valid_r)
    else $error("result presented during clearing pass");

  // One request at a time: a transfer is followed by a busy cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is executing");

  // A free result register always takes the executing request's result.
  a_exec_completes: assert property (@(posedge clk) disable iff (!rst_n)
    (status.exec && !out_valid_r) |=> out_valid_r)
    else $error("executing request did not reach the result register");

  // A pixel row result never carries read data.
  a_row_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_row_valid) |-> (out_read_byte == 8'd0))
    else $error("row result with non-zero read byte");

endmodule

// ===== rtl/tpvr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module tpvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port on the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tpvr_rmw.sv =====
// ----------------------------------------------------------------------------
// Three-plane video RAM: read-modify-write logic
// Merges the data byte into the word read from memory and forms the result.
// ----------------------------------------------------------------------------
module tpvr_rmw (
  input  tpvr_pkg::req_t                 req,
  input  logic [tpvr_pkg::WORD_W-1:0]    rdata,
  output tpvr_pkg::wb_t                  wb,
  output tpvr_pkg::result_t              res
);

  localparam int BW = tpvr_pkg::BYTE_W;

  logic [tpvr_pkg::WORD_W-1:0] new_word;
  logic [BW-1:0]               sel_byte;
  logic [31:0]                 off32;

  // New word after a video write, and the byte a read returns.
  always_comb begin
    new_word = rdata;
    sel_byte = '0;
    case (req.sel)
      tpvr_pkg::SEL_PLANE0: begin
        new_word[0 +: BW] = req.data;
        sel_byte          = rdata[0 +: BW];
      end
      tpvr_pkg::SEL_PLANE1: begin
        new_word[BW +: BW] = req.data;
        sel_byte           = rdata[BW +: BW];
      end
      tpvr_pkg::SEL_PLANE2: begin
        new_word[2*BW +: BW] = req.data;
        sel_byte             = rdata[2*BW +: BW];
      end
      default: begin
        new_word = '0;
        sel_byte = '0;
      end
    endcase
  end

  assign off32 = 32'(tpvr_pkg::plane_addr(req.offset));

  // Write-back only on a video write.
  always_comb begin
    wb.we    = (req.req_type == tpvr_pkg::REQ_WRITE);
    wb.wdata = new_word;
  end

  // Result fields; all zero unless the request type gives them a meaning.
  always_comb begin
    res = '0;
    case (req.req_type)
      tpvr_pkg::REQ_WRITE: begin
        res.row_valid = 1'b1;
        res.pixel_x   = 8'((off32 % tpvr_pkg::BYTES_PER_LINE) * 8);
        res.pixel_y   = 8'(off32 / tpvr_pkg::BYTES_PER_LINE);
        res.pixel_row = tpvr_pkg::build_row(new_word);
      end
      tpvr_pkg::REQ_READ: begin
        res.read_byte = sel_byte;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== rtl/tpvr_seq.sv =====
// ----------------------------------------------------------------------------
// Three-plane video RAM: sequencer
// Runs the clearing pass after reset, takes requests, drives the memory port
// and holds the plane selector.
// ----------------------------------------------------------------------------
module tpvr_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [1:0]                     in_req_type,
  input  logic [tpvr_pkg::OFS_W-1:0]     in_byte_offset,
  input  logic [tpvr_pkg::BYTE_W-1:0]    in_write_byte,
  output logic                           in_stall,
  input  logic                           out_free,
  input  tpvr_pkg::wb_t                  wb,
  output tpvr_pkg::req_t                 req,
  output tpvr_pkg::seq_status_t          status,
  output logic                           ram_we,
  output logic                           ram_re,
  output logic [tpvr_pkg::ADDR_W-1:0]    ram_addr,
  output logic [tpvr_pkg::WORD_W-1:0]    ram_wdata
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  localparam logic [tpvr_pkg::ADDR_W-1:0] LAST_ADDR =
    tpvr_pkg::ADDR_W'(tpvr_pkg::PLANE_BYTES - 1);

  logic [1:0]                    state_r, state_nxt;
  logic [tpvr_pkg::ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [1:0]                    sel_r, sel_nxt;
  logic [1:0]                    req_type_r;
  logic [tpvr_pkg::OFS_W-1:0]    offset_r;
  logic [tpvr_pkg::BYTE_W-1:0]   data_r;
  logic                          accept;
  logic                          done;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = (state_r == ST_EXEC) && out_free;

  // Memory port: clearing sweep, read on a transfer, write-back of a video write on completion.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = tpvr_pkg::plane_addr(offset_r);
    ram_wdata = wb.wdata;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_re   = in_valid;
        ram_addr = tpvr_pkg::plane_addr(in_byte_offset);
      end
      ST_EXEC: begin
        ram_we = wb.we && out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // State, clearing counter and selector updates.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    sel_nxt     = sel_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_nxt = ST_IDLE;
          if (req_type_r == tpvr_pkg::REQ_SELECT) begin
            if (offset_r == tpvr_pkg::SEL_BIT0_OFS) begin
              sel_nxt[0] = data_r[0];
            end else if (offset_r == tpvr_pkg::SEL_BIT1_OFS) begin
              sel_nxt[1] = data_r[0];
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      sel_r     <= tpvr_pkg::SEL_PLANE0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      sel_r     <= sel_nxt;
    end
  end

  // Request registers, loaded on an input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req_type;
      offset_r   <= in_byte_offset;
      data_r     <= in_write_byte;
    end
  end

  always_comb begin
    req.req_type = req_type_r;
    req.offset   = offset_r;
    req.data     = data_r;
    req.sel      = sel_r;
  end

  always_comb begin
    status.clearing = (state_r == ST_CLEAR);
    status.exec     = (state_r == ST_EXEC);
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the three-plane video RAM
// Drives video writes, video reads, selector writes and null requests through
// the valid/stall input channel, with random gaps and random result stalls.
// A shadow copy of the planes and the selector predicts every result that the
// directed table does not fix, and each result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int                CLK_HALF    = 6;
  localparam int                CYCLE_LIMIT = 600000;
  localparam int                RAND_ITEMS  = 900;
  // Request type with no defined meaning: the block must answer with zeros.
  localparam logic [1:0]        REQ_NONE    = 2'd3;
  localparam tpvr_pkg::result_t NO_RESULT   = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [12:0] in_byte_offset;
  logic [7:0]  in_write_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_byte;
  logic        out_row_valid;
  logic [7:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [23:0] out_pixel_row;

  // Shadow state of the block.
  bit [7:0] shadow_plane0 [tpvr_pkg::PLANE_BYTES];
  bit [7:0] shadow_plane1 [tpvr_pkg::PLANE_BYTES];
  bit [7:0] shadow_plane2 [tpvr_pkg::PLANE_BYTES];
  bit [1:0] shadow_sel;

  tpvr_pkg::result_t pending_access_results [$];
  int        mismatches;
  int        results_checked;
  int        sent_by_type [4];
  int        cycle_count;
  bit        calm;
  bit [12:0] hot_ofs [8];

  // One row of the directed table; the expected result is used only when fixed.
  typedef struct {
    logic [1:0]        req;
    logic [12:0]       ofs;
    logic [7:0]        data;
    bit                fixed;
    tpvr_pkg::result_t res;
  } stim_row_t;

  localparam int N_DIRECTED = 24;
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{tpvr_pkg::REQ_READ,   13'd0,    8'h00, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_READ,   13'd8191, 8'h00, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_WRITE,  13'd0,    8'hFF, 1'b1, '{8'h00, 1'b1, 8'd0, 8'd0, 24'h924924}},
    '{tpvr_pkg::REQ_WRITE,  13'd8191, 8'hA5, 1'b0, NO_RESULT},
    '{REQ_NONE,             13'd8191, 8'hFF, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_SELECT, 13'd0,    8'h01, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_WRITE,  13'd0,    8'hFF, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_SELECT, 13'd2,    8'h01, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_READ,   13'd0,    8'h00, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_SELECT, 13'd1,    8'h01, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_READ,   13'd0,    8'h00, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_WRITE,  13'd0,    8'h55, 1'b1, '{8'h00, 1'b1, 8'd0, 8'd0, 24'h000000}},
    '{tpvr_pkg::REQ_SELECT, 13'd0,    8'h00, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_WRITE,  13'd0,    8'h80, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_READ,   13'd0,    8'h00, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_WRITE,  13'd31,   8'h01, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_WRITE,  13'd32,   8'h7E, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_SELECT, 13'd8191, 8'hFF, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_SELECT, 13'd1,    8'hFE, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_READ,   13'd8191, 8'h00, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_WRITE,  13'd4096, 8'h00, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_SELECT, 13'd0,    8'hFF, 1'b1, NO_RESULT},
    '{tpvr_pkg::REQ_READ,   13'd8191, 8'h00, 1'b0, NO_RESULT},
    '{tpvr_pkg::REQ_SELECT, 13'd0,    8'h00, 1'b1, NO_RESULT}
  };

  three_plane_video_ram dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_byte_offset (in_byte_offset),
    .in_write_byte  (in_write_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte),
    .out_row_valid  (out_row_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_row  (out_pixel_row)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one access to the shadow planes and return the result it causes.
  function automatic tpvr_pkg::result_t video_access(logic [1:0] req, logic [12:0] ofs,
                                                     logic [7:0] data);
    tpvr_pkg::result_t r;
    int unsigned       a;
    bit [7:0]          b0;
    bit [7:0]          b1;
    bit [7:0]          b2;
    r = '0;
    a = ofs % tpvr_pkg::PLANE_BYTES;
    case (req)
      tpvr_pkg::REQ_WRITE: begin
        case (shadow_sel)
          tpvr_pkg::SEL_PLANE0: shadow_plane0[a] = data;
          tpvr_pkg::SEL_PLANE1: shadow_plane1[a] = data;
          tpvr_pkg::SEL_PLANE2: shadow_plane2[a] = data;
          default: begin
            shadow_plane0[a] = '0;
            shadow_plane1[a] = '0;
            shadow_plane2[a] = '0;
          end
        endcase
        b0 = shadow_plane0[a];
        b1 = shadow_plane1[a];
        b2 = shadow_plane2[a];
        r.row_valid = 1'b1;
        r.pixel_x   = 8'((a % tpvr_pkg::BYTES_PER_LINE) * 8);
        r.pixel_y   = 8'(a / tpvr_pkg::BYTES_PER_LINE);
        // Leftmost pixel comes from bit 7 of each plane, plane 0 as its MSB.
        for (int i = 0; i < 8; i++) begin
          r.pixel_row[3*i +: 3] = {b0[7-i], b1[7-i], b2[7-i]};
        end
      end
      tpvr_pkg::REQ_READ: begin
        case (shadow_sel)
          tpvr_pkg::SEL_PLANE0: r.read_byte = shadow_plane0[a];
          tpvr_pkg::SEL_PLANE1: r.read_byte = shadow_plane1[a];
          tpvr_pkg::SEL_PLANE2: r.read_byte = shadow_plane2[a];
          default:              r.read_byte = '0;
        endcase
      end
      tpvr_pkg::REQ_SELECT: begin
        if (ofs == tpvr_pkg::SEL_BIT0_OFS) begin
          shadow_sel[0] = data[0];
        end else if (ofs == tpvr_pkg::SEL_BIT1_OFS) begin
          shadow_sel[1] = data[0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one, none in a calm stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Present one request, wait for its transfer and record what it should give.
  task automatic send_access(input logic [1:0] req, input logic [12:0] ofs,
                             input logic [7:0] data, input bit fixed,
                             input tpvr_pkg::result_t fixed_res);
    tpvr_pkg::result_t predicted;
    int                gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) begin
        in_req_type    <= 2'($urandom);
        in_byte_offset <= 13'($urandom);
        in_write_byte  <= 8'($urandom);
        @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_byte_offset <= ofs;
    in_write_byte  <= data;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = video_access(req, ofs, data);
    pending_access_results.push_back(fixed ? fixed_res : predicted);
    sent_by_type[req]++;
    @(negedge clk);
  endtask

  // Result side stall pattern: free runs broken by stalls of random length.
  int stall_left;
  int free_left;
  always @(negedge clk) begin
    if (!calm && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (free_left > 0) begin
        free_left--;
      end else begin
        stall_left = pick_gap();
        free_left  = $urandom_range(0, 20);
      end
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    tpvr_pkg::result_t got;
    tpvr_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.read_byte = out_read_byte;
      got.row_valid = out_row_valid;
      got.pixel_x   = out_pixel_x;
      got.pixel_y   = out_pixel_y;
      got.pixel_row = out_pixel_row;
      if (pending_access_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result: read %02h row_valid %0b x %0d y %0d row %06h",
                   $time, got.read_byte, got.row_valid, got.pixel_x, got.pixel_y,
                   got.pixel_row);
        end
      end else begin
        want = pending_access_results.pop_front();
        results_checked++;
        if (got.read_byte !== want.read_byte || got.row_valid !== want.row_valid ||
            got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
            got.pixel_row !== want.pixel_row) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch: expected read %02h row_valid %0b x %0d y %0d row %06h",
                     $time, want.read_byte, want.row_valid, want.pixel_x, want.pixel_y,
                     want.pixel_row);
            $display("%0t:           got      read %02h row_valid %0b x %0d y %0d row %06h",
                     $time, got.read_byte, got.row_valid, got.pixel_x, got.pixel_y,
                     got.pixel_row);
          end
        end
      end
    end
  end

  // Watchdog; the clearing pass after reset is well inside the limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_access_results.size());
      $display("** three_plane_video_ram: FAILED **");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin
    int          r;
    logic [1:0]  req;
    logic [12:0] ofs;
    logic [7:0]  data;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = '0;
    in_byte_offset = '0;
    in_write_byte  = '0;
    calm           = 1'b0;
    shadow_sel     = tpvr_pkg::SEL_PLANE0;
    hot_ofs[0] = 13'd0;
    hot_ofs[1] = 13'd8191;
    hot_ofs[2] = 13'd31;
    hot_ofs[3] = 13'd32;
    for (int h = 4; h < 8; h++) begin
      hot_ofs[h] = 13'($urandom);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_access(directed_rows[i].req, directed_rows[i].ofs, directed_rows[i].data,
                  directed_rows[i].fixed, directed_rows[i].res);
    end

    // Random traffic around a few busy offsets so that reads find written data.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      calm = (k >= 350 && k < 450);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        req = tpvr_pkg::REQ_WRITE;
      end else if (r < 75) begin
        req = tpvr_pkg::REQ_READ;
      end else if (r < 95) begin
        req = tpvr_pkg::REQ_SELECT;
      end else begin
        req = REQ_NONE;
      end
      if (req == tpvr_pkg::REQ_SELECT) begin
        ofs = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1));
      end else begin
        ofs = ($urandom_range(0, 9) < 6) ? hot_ofs[$urandom_range(0, 7)] : 13'($urandom);
      end
      data = 8'($urandom);
      send_access(req, ofs, data, 1'b0, NO_RESULT);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_access_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d video writes, %0d video reads, %0d selector writes, %0d null requests.",
             sent_by_type[tpvr_pkg::REQ_WRITE], sent_by_type[tpvr_pkg::REQ_READ],
             sent_by_type[tpvr_pkg::REQ_SELECT], sent_by_type[REQ_NONE]);
    $display("Checked %0d results, %0d failures, in %0d cycles.",
             results_checked, mismatches, cycle_count);
    if (mismatches == 0 && pending_access_results.size() == 0) begin
      $display("** three_plane_video_ram: PASSED **");
    end else begin
      $display("** three_plane_video_ram: FAILED **");
    end
    $finish;
  end

endmodule
